@@ design/multi_curve_soft_clipper_unit_defines.svh @@
// Assertion macros used by the soft clipper top level.
`ifndef MULTI_CURVE_SOFT_CLIPPER_UNIT_DEFINES_SVH
`define MULTI_CURVE_SOFT_CLIPPER_UNIT_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define MCSC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mcsc: same-cycle check failed");

// The consequent holds a fixed number of cycles after the antecedent.
`define MCSC_ASSERT_DELAY(label, ante, n, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error("mcsc: delayed check failed");

`endif

@@ design/mcsc_pkg.sv @@
// Types, constants and exponent tables of the soft clipper.
package mcsc_pkg;

  typedef enum logic [2:0] {
    CURVE_SMOOTH = 3'd0,
    CURVE_CRISP  = 3'd1,
    CURVE_TUBE   = 3'd2,
    CURVE_TAPE   = 3'd3,
    CURVE_GUITAR = 3'd4
  } curve_t;

  typedef enum logic [1:0] {
    REG_CLIPPER_ON   = 2'd0,
    REG_CURVE_MODE   = 2'd1,
    REG_DRIVE_AMOUNT = 2'd2,
    REG_WET_MIX      = 2'd3
  } reg_index_t;

  localparam int REG_DATA_W = 17;
  localparam int CORE_FRAC  = 21;
  localparam int QUO_W      = 23;
  // Front stages, divider stages, guitar/crisp alignment and the mix tail.
  localparam int PIPE_DEPTH = QUO_W + 9;

  localparam int INPUT_LIMIT  = 4194304;    // 2.0 in Q.21
  localparam int CORE_ONE     = 2097152;    // 1.0 in Q.21
  localparam int TANH_LIMIT   = 18874368;   // 9.0 in Q.21
  localparam int TANH_A_Q21   = 56623104;   // 27.0 in Q.21
  localparam int E_ONE        = 16777216;   // 1.0 in Q.24
  localparam int TUBE_NEG     = 55706;
  localparam int GUITAR_NEG   = 60293;
  localparam int DIV6_RECIP   = 43691;      // 2^18 / 6, rounded up
  localparam int DRY_LIMIT    = 65470;
  localparam int FULL_WET     = 65536;
  localparam int DRIVE_BASE   = 65536;

  typedef struct packed {
    logic        on;
    curve_t      curve;
    logic [19:0] drive;
    logic [16:0] wet;
    logic        full_wet;
  } shape_cfg_t;

  // exp(-i) in Q.24 for the integer part, saturating at ten.
  function automatic logic [24:0] exp_int_q24(input logic [3:0] i);
    logic [24:0] v;
    case (i)
      4'd0: v = 25'd16777216;
      4'd1: v = 25'd6171993;
      4'd2: v = 25'd2270549;
      4'd3: v = 25'd835288;
      4'd4: v = 25'd307285;
      4'd5: v = 25'd113044;
      4'd6: v = 25'd41587;
      4'd7: v = 25'd15299;
      4'd8: v = 25'd5628;
      4'd9: v = 25'd2070;
      default: v = 25'd762;
    endcase
    return v;
  endfunction

  // exp(-j/16) in Q.24.
  function automatic logic [24:0] exp_frac_q24(input logic [3:0] j);
    logic [24:0] v;
    case (j)
      4'd0:  v = 25'd16777216;
      4'd1:  v = 25'd15760736;
      4'd2:  v = 25'd14805841;
      4'd3:  v = 25'd13908801;
      4'd4:  v = 25'd13066109;
      4'd5:  v = 25'd12274473;
      4'd6:  v = 25'd11530801;
      4'd7:  v = 25'd10832185;
      4'd8:  v = 25'd10175896;
      4'd9:  v = 25'd9559370;
      4'd10: v = 25'd8980197;
      4'd11: v = 25'd8436114;
      4'd12: v = 25'd7924996;
      4'd13: v = 25'd7444844;
      4'd14: v = 25'd6993784;
      default: v = 25'd6570052;
    endcase
    return v;
  endfunction

endpackage

@@ design/multi_curve_soft_clipper_unit.sv @@
// Top level of the stereo soft clipper: configuration registers, beat tracking, two channels.
//
// Takes one stereo frame per clock cycle and returns it shaped on the cycle when done is
// high for one cycle; results cannot be held off. The pipeline holds the 23-stage restoring
// divider that evaluates the tanh and tape curves, plus the drive, polynomial and mix
// stages around it. busy is high only while rst is high. Registers are written with wr_en,
// wr_index and wr_data and must only change while no frame is in flight.
`include "multi_curve_soft_clipper_unit_defines.svh"

module multi_curve_soft_clipper_unit #(
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [SAMPLE_WIDTH-1:0]      sample_left,
  input  logic signed [SAMPLE_WIDTH-1:0]      sample_right,
  input  logic                                wr_en,
  input  mcsc_pkg::reg_index_t                wr_index,
  input  logic [mcsc_pkg::REG_DATA_W-1:0]     wr_data,
  output logic                                done,
  output logic signed [SAMPLE_WIDTH-1:0]      out_left,
  output logic signed [SAMPLE_WIDTH-1:0]      out_right
);
  import mcsc_pkg::*;

  logic        clipper_on;
  logic [2:0]  curve_mode;
  logic [15:0] drive_amount;
  logic [16:0] wet_mix;
  logic        accept;
  logic [PIPE_DEPTH-1:0] vld;
  shape_cfg_t  cfg;

  assign busy   = rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      clipper_on   <= 1'b1;
      curve_mode   <= 3'(CURVE_SMOOTH);
      drive_amount <= '0;
      wet_mix      <= 17'(FULL_WET);
    end else if (wr_en) begin
      case (wr_index)
        REG_CLIPPER_ON:   clipper_on   <= wr_data[0];
        REG_CURVE_MODE:   curve_mode   <= wr_data[2:0];
        REG_DRIVE_AMOUNT: drive_amount <= wr_data[15:0];
        REG_WET_MIX:      wet_mix      <= wr_data[16:0];
        default: ;
      endcase
    end
  end

  // Curve codes above guitar act as guitar; wet above full acts as full.
  always_comb begin
    cfg.on       = clipper_on;
    cfg.curve    = (curve_mode > 3'(CURVE_GUITAR)) ? CURVE_GUITAR : curve_t'(curve_mode);
    cfg.drive    = 20'(DRIVE_BASE) + {1'b0, drive_amount, 3'b000} + 20'(drive_amount);
    cfg.wet      = (wet_mix > 17'(FULL_WET)) ? 17'(FULL_WET) : wet_mix;
    cfg.full_wet = cfg.wet > 17'(DRY_LIMIT);
  end

  // One valid bit per stage follows each beat down the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PIPE_DEPTH-2:0], accept};
    end
  end

  assign done = vld[PIPE_DEPTH-1];

  mcsc_channel #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_left (
    .clk    (clk),
    .cfg    (cfg),
    .sample (sample_left),
    .result (out_left)
  );

  mcsc_channel #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_right (
    .clk    (clk),
    .cfg    (cfg),
    .sample (sample_right),
    .result (out_right)
  );

  `MCSC_ASSERT_DELAY(a_beat_delivered, accept, PIPE_DEPTH, done)
  `MCSC_ASSERT_DELAY(a_no_spurious_beat, !accept, PIPE_DEPTH, !done)
  `MCSC_ASSERT_NOW(a_bypass_exact, done && !$past(clipper_on), out_left == $past(sample_left, PIPE_DEPTH) && out_right == $past(sample_right, PIPE_DEPTH))

endmodule

@@ design/mcsc_channel.sv @@
// One channel of the soft clipper: drive, curve shaping, divider and dry/wet mix.
module mcsc_channel #(
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                           clk,
  input  mcsc_pkg::shape_cfg_t           cfg,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  output logic signed [SAMPLE_WIDTH-1:0] result
);
  import mcsc_pkg::*;

  localparam int SW     = SAMPLE_WIDTH;
  localparam int UP     = CORE_FRAC - (SW - 3);
  localparam int ND_LEN = QUO_W - 1;

  // Sign and dry sample ride along with the item.
  logic                 neg_d [PIPE_DEPTH-3];
  logic signed [SW-1:0] dry_d [PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    neg_d[0] <= sample[SW-1];
    dry_d[0] <= sample;
    for (int k = 1; k < PIPE_DEPTH - 3; k++) neg_d[k] <= neg_d[k-1];
    for (int k = 1; k < PIPE_DEPTH - 1; k++) dry_d[k] <= dry_d[k-1];
  end

  // Stage 1: move to Q.21 and clamp to two.
  logic [SW-1:0] sample_u;
  logic [SW-1:0] abs_in;
  logic [23:0]   in_mag;
  logic [22:0]   s1_mag;

  assign sample_u = sample;
  assign abs_in   = sample[SW-1] ? (~sample_u + SW'(1)) : sample_u;

  generate
    if (UP >= 0) begin : g_in_up
      assign in_mag = 24'(abs_in) << UP;
    end else begin : g_in_dn
      localparam int DN = -UP;
      logic [SW:0] rsum;
      assign rsum   = {1'b0, abs_in} + ((SW+1)'(1) << (DN - 1));
      assign in_mag = 24'(rsum >> DN);
    end
  endgenerate

  always_ff @(posedge clk) begin
    s1_mag <= (in_mag > 24'(INPUT_LIMIT)) ? 23'(INPUT_LIMIT) : in_mag[22:0];
  end

  // Stage 2: apply drive.
  logic [42:0] s2_sum;
  logic [24:0] s2_m;

  assign s2_sum = 43'(s1_mag) * 43'(cfg.drive) + 43'(65536);

  always_ff @(posedge clk) begin
    s2_m <= s2_sum[41:17];
  end

  // Stage 3: tube scaling, squares and exponent table product.
  logic [40:0] tube_sum;
  logic [24:0] m_sel;
  logic [48:0] sq_sum;
  logic [19:0] r_frac;
  logic [39:0] r2_sum;
  logic [49:0] tab_sum;
  logic [24:0] s3_mt, s3_m, s3_e;
  logic [27:0] s3_sq;
  logic [19:0] s3_r;
  logic [15:0] s3_r2;

  assign tube_sum = 41'(s2_m) * 41'(TUBE_NEG) + 41'(32768);
  assign m_sel    = (cfg.curve == CURVE_TUBE && neg_d[1]) ? tube_sum[40:16] : s2_m;
  assign sq_sum   = 49'(s2_m) * 49'(s2_m) + 49'(1048576);
  assign r_frac   = {s2_m[16:0], 3'b000};
  assign r2_sum   = 40'(r_frac) * 40'(r_frac) + 40'(8388608);
  assign tab_sum  = 50'(exp_int_q24(s2_m[24:21])) * 50'(exp_frac_q24(s2_m[20:17]))
                  + 50'(8388608);

  always_ff @(posedge clk) begin
    s3_mt <= (m_sel > 25'(TANH_LIMIT)) ? 25'(TANH_LIMIT) : m_sel;
    s3_m  <= s2_m;
    s3_sq <= sq_sum[48:21];
    s3_r  <= r_frac;
    s3_r2 <= r2_sum[39:24];
    s3_e  <= tab_sum[48:24];
  end

  // Stage 4: tanh square, crisp cube, guitar cubic remainder.
  logic [48:0] sqt_sum;
  logic [41:0] m3_sum;
  logic [36:0] r3_sum;
  logic [27:0] s4_sqt, s4_sq;
  logic [20:0] s4_m3;
  logic [12:0] s4_r3;
  logic [24:0] s4_mt, s4_m, s4_e;
  logic [19:0] s4_r;
  logic [15:0] s4_r2;

  assign sqt_sum = 49'(s3_mt) * 49'(s3_mt) + 49'(1048576);
  assign m3_sum  = 42'(s3_m[20:0]) * 42'(s3_sq[20:0]) + 42'(1048576);
  assign r3_sum  = 37'(s3_r2) * 37'(s3_r) + 37'(8388608);

  always_ff @(posedge clk) begin
    s4_sqt <= sqt_sum[48:21];
    s4_m3  <= m3_sum[41:21];
    s4_r3  <= r3_sum[36:24];
    s4_mt  <= s3_mt;
    s4_m   <= s3_m;
    s4_sq  <= s3_sq;
    s4_e   <= s3_e;
    s4_r   <= s3_r;
    s4_r2  <= s3_r2;
  end

  // Stage 5: tanh numerator and denominator, tape operands, crisp result, guitar polynomial.
  logic [27:0] tanh_sum;
  logic [22:0] m_x3;
  logic [22:0] crisp_diff;
  logic [21:0] crisp_y;
  logic [28:0] q6_prod;
  logic [52:0] s5_num;
  logic [30:0] s5_den;
  logic [45:0] s5_tnum;
  logic [27:0] s5_tden;
  logic [21:0] s5_yc;
  logic [24:0] s5_p, s5_e;

  assign tanh_sum   = 28'(TANH_A_Q21) + s4_sqt;
  assign m_x3       = {1'b0, s4_m[20:0], 1'b0} + 23'(s4_m[20:0]);
  assign crisp_diff = m_x3 - 23'(s4_m3);
  assign q6_prod    = 29'(s4_r3 + 13'd3) * 29'(DIV6_RECIP);

  always_comb begin
    if (|s4_m[24:21]) begin
      crisp_y = 22'(CORE_ONE);
    end else if (23'(s4_m3) > m_x3) begin
      crisp_y = '0;
    end else begin
      crisp_y = 22'((24'(crisp_diff) + 24'd1) >> 1);
    end
  end

  always_ff @(posedge clk) begin
    s5_num  <= 53'(s4_mt) * 53'(tanh_sum);
    s5_den  <= 31'(TANH_A_Q21) + {s4_sqt, 3'b000} + 31'(s4_sqt);
    s5_tnum <= {s4_m, 21'b0};
    s5_tden <= 28'(CORE_ONE) + s4_sq;
    s5_yc   <= crisp_y;
    s5_p    <= 25'(E_ONE) - 25'(s4_r) + 25'(s4_r2 >> 1) - 25'(q6_prod[28:18]);
    s5_e    <= s4_e;
  end

  // Stage 6: divider load (rounded quotient) and exp product.
  logic        use_tanh;
  logic        use_div;
  logic [52:0] n_sel;
  logic [30:0] d_sel;
  logic [49:0] ep_sum;
  logic [24:0] s6_ep;
  logic [21:0] s6_yc;
  logic [52:0] dv_rem [QUO_W];
  logic [30:0] dv_den [QUO_W];
  logic [QUO_W-1:0] dv_quo [1:QUO_W];

  assign use_tanh = (cfg.curve == CURVE_SMOOTH) || (cfg.curve == CURVE_TUBE);
  assign use_div  = use_tanh || (cfg.curve == CURVE_TAPE);
  assign n_sel    = use_tanh ? s5_num : 53'(s5_tnum);
  assign d_sel    = use_tanh ? s5_den : 31'(s5_tden);
  assign ep_sum   = 50'(s5_e) * 50'(s5_p) + 50'(8388608);

  always_ff @(posedge clk) begin
    dv_rem[0] <= n_sel + 53'(d_sel >> 1);
    dv_den[0] <= d_sel;
    s6_ep     <= ep_sum[48:24];
    s6_yc     <= s5_yc;
  end

  // Restoring divider, one quotient bit per stage, most significant first.
  generate
    for (genvar k = 0; k < QUO_W; k++) begin : g_div
      localparam int B = QUO_W - 1 - k;
      logic [53:0] dshift;
      logic        ge;
      assign dshift = 54'(dv_den[k]) << B;
      assign ge     = {1'b0, dv_rem[k]} >= dshift;
      if (k == 0) begin : g_first
        always_ff @(posedge clk) begin
          dv_quo[1] <= QUO_W'(ge) << B;
        end
      end else begin : g_next
        always_ff @(posedge clk) begin
          dv_quo[k+1] <= dv_quo[k] | (QUO_W'(ge) << B);
        end
      end
      if (k < QUO_W - 1) begin : g_rem
        always_ff @(posedge clk) begin
          dv_rem[k+1] <= ge ? 53'({1'b0, dv_rem[k]} - dshift) : dv_rem[k];
          dv_den[k+1] <= dv_den[k];
        end
      end
    end
  endgenerate

  // Stages 7 and 8: guitar curve finish and crisp/guitar select.
  logic [25:0] g_base_sum;
  logic [21:0] g_base;
  logic [37:0] g_scaled;
  logic [21:0] s7_yg, s7_yc;
  logic [21:0] nd_d [ND_LEN];

  assign g_base_sum = 26'(E_ONE) - 26'(s6_ep) + 26'd4;
  assign g_base     = g_base_sum[24:3];
  assign g_scaled   = 38'(g_base) * 38'(GUITAR_NEG) + 38'(32768);

  always_ff @(posedge clk) begin
    s7_yg <= neg_d[5] ? g_scaled[37:16] : g_base;
    s7_yc <= s6_yc;
    if (cfg.curve == CURVE_CRISP) begin
      nd_d[0] <= s7_yc;
    end else begin
      nd_d[0] <= (s7_yg > 22'(CORE_ONE)) ? 22'(CORE_ONE) : s7_yg;
    end
    for (int k = 1; k < ND_LEN; k++) nd_d[k] <= nd_d[k-1];
  end

  // Stage 30: pick the curve value, apply sign, scale back to the port format.
  logic [QUO_W-1:0] y_fin;
  logic [31:0]      out_mag;
  logic [SW-1:0]    wet_v;
  logic signed [SW-1:0] s30_wet;

  assign y_fin = use_div ? dv_quo[QUO_W] : QUO_W'(nd_d[ND_LEN-1]);

  generate
    if (UP > 0) begin : g_out_dn
      assign out_mag = (32'(y_fin) + (32'(1) << (UP - 1))) >> UP;
    end else if (UP == 0) begin : g_out_eq
      assign out_mag = 32'(y_fin);
    end else begin : g_out_up
      assign out_mag = 32'(y_fin) << (-UP);
    end
  endgenerate

  assign wet_v = neg_d[28] ? (SW'(0) - SW'(out_mag)) : SW'(out_mag);

  always_ff @(posedge clk) begin
    s30_wet <= wet_v;
  end

  // Stage 31: (wet - dry) * w, so the mix needs a single multiplier.
  logic signed [SW:0]    mix_diff;
  logic signed [SW+18:0] s31_prod;
  logic signed [SW-1:0]  s31_wet;

  assign mix_diff = {s30_wet[SW-1], s30_wet} - {dry_d[29][SW-1], dry_d[29]};

  always_ff @(posedge clk) begin
    s31_prod <= mix_diff * $signed({1'b0, cfg.wet});
    s31_wet  <= s30_wet;
  end

  // Stage 32: dry * 65536 + product, rounded half away from zero; dry when off, wet when full wet.
  logic signed [SW+19:0] acc;
  logic [SW+19:0]        acc_mag;
  logic [SW+19:0]        acc_rnd;
  logic [SW-1:0]         mixed;

  assign acc     = {{4{dry_d[30][SW-1]}}, dry_d[30], 16'b0} + {s31_prod[SW+18], s31_prod};
  assign acc_mag = acc[SW+19] ? ((SW+20)'(0) - acc) : acc;
  assign acc_rnd = (acc_mag + (SW+20)'(32768)) >> 16;
  assign mixed   = acc[SW+19] ? (SW'(0) - acc_rnd[SW-1:0]) : acc_rnd[SW-1:0];

  always_ff @(posedge clk) begin
    if (!cfg.on) begin
      result <= dry_d[30];
    end else if (cfg.full_wet) begin
      result <= s31_wet;
    end else begin
      result <= mixed;
    end
  end

endmodule

@@ sim/tb_multi_curve_soft_clipper_unit.sv @@
// Self-checking testbench of the stereo soft clipper: directed table, curve sweep, then random frames.
`timescale 1ns / 100ps

module tb_multi_curve_soft_clipper_unit;
  import mcsc_pkg::*;

  localparam int SW = 24;
  localparam int LATENCY = PIPE_DEPTH;
  localparam int N_RANDOM = 1750;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [SW-1:0] sample_left = '0;
  logic signed [SW-1:0] sample_right = '0;
  logic wr_en = 1'b0;
  reg_index_t wr_index = REG_CLIPPER_ON;
  logic [REG_DATA_W-1:0] wr_data = '0;
  logic done;
  logic signed [SW-1:0] out_left;
  logic signed [SW-1:0] out_right;

  typedef struct {
    logic signed [SW-1:0] left;
    logic signed [SW-1:0] right;
  } frame_t;

  typedef struct {
    logic signed [SW-1:0] in_l;
    logic signed [SW-1:0] in_r;
    logic                 known;
    logic signed [SW-1:0] out_l;
    logic signed [SW-1:0] out_r;
  } beat_row_t;

  frame_t shaped_q[$];
  int errors = 0;

  // Local copy of the registers.
  logic       cfg_on;
  logic [2:0] cfg_curve;
  logic [15:0] cfg_drive;
  logic [16:0] cfg_wet;

  localparam longint ONE21 = 64'd1 << 21;
  localparam longint ONE24 = 64'd1 << 24;

  longint unsigned exp_int_tab[11] = '{16777216, 6171993, 2270549, 835288, 307285,
                                       113044, 41587, 15299, 5628, 2070, 762};
  longint unsigned exp_frac_tab[16] = '{16777216, 15760736, 14805841, 13908801, 13066109,
                                        12274473, 11530801, 10832185, 10175896, 9559370,
                                        8980197, 8436114, 7924996, 7444844, 6993784,
                                        6570052};

  multi_curve_soft_clipper_unit #(.SAMPLE_WIDTH(SW)) i_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Right shift with rounding half away from zero.
  function automatic longint round_shift(input longint a, input int n);
    longint unsigned mag;
    mag = (a < 0) ? -a : a;
    mag = (mag + (64'd1 << (n - 1))) >> n;
    return (a < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint unsigned uround_shift(input longint unsigned a, input int n);
    return (a + (64'd1 << (n - 1))) >> n;
  endfunction

  function automatic longint unsigned tanh_approx(input longint unsigned m);
    longint unsigned m2, num, den;
    if (m > 9 * ONE21) m = 9 * ONE21;
    m2 = uround_shift(m * m, 21);
    num = m * (27 * ONE21 + m2);
    den = 27 * ONE21 + 9 * m2;
    return (num + den / 2) / den;
  endfunction

  function automatic longint unsigned exp_decay(input longint unsigned m);
    longint unsigned i, f, j, r, r2, r3, p, e;
    i = m >> 21;
    f = m & (ONE21 - 1);
    j = (f >> 17) & 15;
    r = (f & ((64'd1 << 17) - 1)) << 3;
    if (i > 10) i = 10;
    r2 = uround_shift(r * r, 24);
    r3 = uround_shift(r2 * r, 24);
    p = ONE24 - r + r2 / 2 - (r3 + 3) / 6;
    e = uround_shift(exp_int_tab[i] * exp_frac_tab[j], 24);
    return uround_shift(e * p, 24);
  endfunction

  function automatic logic signed [SW-1:0] clip_channel(input logic signed [SW-1:0] smp);
    longint x, drive, v, wet, res;
    longint unsigned m, y, m2, m3, e;
    logic neg;
    curve_t curve;
    longint unsigned w;
    if (!cfg_on) return smp;
    curve = (cfg_curve > 3'd4) ? CURVE_GUITAR : curve_t'(cfg_curve);
    w = (cfg_wet > 17'd65536) ? 65536 : cfg_wet;
    drive = 65536 + 9 * longint'(cfg_drive);
    x = smp;
    if (x > 2 * ONE21) x = 2 * ONE21;
    if (x < -2 * ONE21) x = -2 * ONE21;
    v = round_shift(x * drive, 17);
    neg = v < 0;
    m = neg ? -v : v;
    case (curve)
      CURVE_SMOOTH: y = tanh_approx(m);
      CURVE_CRISP: begin
        if (m >= ONE21) begin
          y = ONE21;
        end else begin
          m2 = uround_shift(m * m, 21);
          m3 = uround_shift(m2 * m, 21);
          y = (m3 > 3 * m) ? 0 : (3 * m - m3 + 1) >> 1;
        end
      end
      CURVE_TUBE: begin
        if (neg) m = uround_shift(m * TUBE_NEG, 16);
        y = tanh_approx(m);
      end
      CURVE_TAPE: begin
        m2 = uround_shift(m * m, 21);
        y = ((m << 21) + (ONE21 + m2) / 2) / (ONE21 + m2);
      end
      default: begin
        e = exp_decay(m);
        y = (ONE24 - e + 4) >> 3;
        if (neg) y = uround_shift(y * GUITAR_NEG, 16);
        if (y > ONE21) y = ONE21;
      end
    endcase
    wet = neg ? -longint'(y) : longint'(y);
    if (w <= DRY_LIMIT) res = round_shift(longint'(smp) * longint'(65536 - w)
                                          + wet * longint'(w), 16);
    else res = wet;
    return res[SW-1:0];
  endfunction

  task automatic write_reg(input reg_index_t idx, input logic [REG_DATA_W-1:0] val);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    case (idx)
      REG_CLIPPER_ON:   cfg_on = val[0];
      REG_CURVE_MODE:   cfg_curve = val[2:0];
      REG_DRIVE_AMOUNT: cfg_drive = val[15:0];
      default:          cfg_wet = val;
    endcase
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  // Waits for the pipeline to drain before a register change.
  task automatic drain;
    int guard;
    guard = 0;
    while (shaped_q.size() != 0 && guard < 100000) begin
      @(negedge clk);
      guard++;
    end
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  // Presents one frame; start stays high through back-to-back beats.
  task automatic send_frame(input logic signed [SW-1:0] l, input logic signed [SW-1:0] r,
                            input logic gaps);
    frame_t f;
    if (gaps) begin
      while ($urandom_range(99) < 25) begin
        start <= 1'b0;
        @(negedge clk);
      end
    end
    start <= 1'b1;
    sample_left <= l;
    sample_right <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    f.left = clip_channel(l);
    f.right = clip_channel(r);
    shaped_q.push_back(f);
    @(negedge clk);
  endtask

  task automatic idle_start;
    start <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic signed [SW-1:0] rand_sample;
    case ($urandom_range(5))
      0: return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
      1: return SW'($signed($urandom_range(8388607)) - 4194304) >>> $urandom_range(8);
      default: return SW'($urandom);
    endcase
  endfunction

  // Results checked field by field against the oldest expectation.
  always @(posedge clk) begin
    frame_t f;
    if (!rst && done) begin
      if (shaped_q.size() == 0) begin
        $error("unexpected result beat: out_left %0d out_right %0d", out_left, out_right);
        errors++;
      end else begin
        f = shaped_q.pop_front();
        if (out_left !== f.left) begin
          $error("out_left expected %0d actual %0d", f.left, out_left);
          errors++;
        end
        if (out_right !== f.right) begin
          $error("out_right expected %0d actual %0d", f.right, out_right);
          errors++;
        end
      end
    end
  end

  // Directed rows; known ones follow from the defaults (smooth, drive 0.5, fully wet).
  beat_row_t directed[] = '{
    '{24'sd0, 24'sd0, 1'b1, 24'sd0, 24'sd0},
    '{24'sh7FFFFF, 24'sh800000, 1'b0, 24'sd0, 24'sd0},
    '{24'sd1, -24'sd1, 1'b0, 24'sd0, 24'sd0},
    '{24'sd2097152, -24'sd2097152, 1'b0, 24'sd0, 24'sd0},
    '{24'sd4194304, -24'sd4194304, 1'b0, 24'sd0, 24'sd0},
    '{24'sd4194305, -24'sd4194305, 1'b0, 24'sd0, 24'sd0},
    '{24'sd1048576, -24'sd524288, 1'b0, 24'sd0, 24'sd0},
    '{24'sh555555, 24'shAAAAAA, 1'b0, 24'sd0, 24'sd0}
  };

  initial begin
    frame_t f;
    int curve_i;
    cfg_on = 1'b1;
    cfg_curve = CURVE_SMOOTH;
    cfg_drive = '0;
    cfg_wet = 17'd65536;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed[k]) begin
      send_frame(directed[k].in_l, directed[k].in_r, 1'b0);
      if (directed[k].known) begin
        f.left = directed[k].out_l;
        f.right = directed[k].out_r;
        shaped_q[shaped_q.size() - 1] = f;
      end
    end
    idle_start();

    // Every curve, including codes above guitar; drive alternates between its extremes, mix between full and half.
    for (curve_i = 0; curve_i < 8; curve_i++) begin
      drain();
      write_reg(REG_CURVE_MODE, REG_DATA_W'(curve_i));
      write_reg(REG_DRIVE_AMOUNT, (curve_i % 2) ? 17'd65535 : 17'd0);
      write_reg(REG_WET_MIX, (curve_i % 3 == 0) ? 17'd65536 : 17'd32768);
      send_frame(24'sh7FFFFF, 24'sh800000, 1'b0);
      send_frame(24'sd700000, -24'sd700000, 1'b0);
      idle_start();
    end

    // Random phases, each with its own setting.
    for (int ph = 0; ph < 35; ph++) begin
      drain();
      write_reg(REG_CLIPPER_ON, ($urandom_range(9) != 0) ? 17'd1 : 17'h1FFFE);
      write_reg(REG_CURVE_MODE, REG_DATA_W'($urandom_range(7)));
      case ($urandom_range(3))
        0: write_reg(REG_DRIVE_AMOUNT, 17'd0);
        1: write_reg(REG_DRIVE_AMOUNT, 17'hFFFF);
        default: write_reg(REG_DRIVE_AMOUNT, REG_DATA_W'($urandom));
      endcase
      case ($urandom_range(5))
        0: write_reg(REG_WET_MIX, 17'd0);
        1: write_reg(REG_WET_MIX, 17'd65470);
        2: write_reg(REG_WET_MIX, 17'd65471);
        3: write_reg(REG_WET_MIX, 17'h1FFFF);
        default: write_reg(REG_WET_MIX, REG_DATA_W'($urandom_range(65536)));
      endcase
      for (int n = 0; n < N_RANDOM / 35; n++)
        send_frame(rand_sample(), rand_sample(), ph % 4 != 1);
      idle_start();
    end

    drain();
    if (shaped_q.size() != 0) begin
      $error("%0d result beats never arrived", shaped_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
